### rtl/gaq_pkg.sv
`default_nettype none
package gaq_pkg;

    // group buffer geometry
    localparam int GROUP_MAX = 32;
    localparam int IDX_W     = $clog2(GROUP_MAX);
    localparam int CNT_W     = $clog2(GROUP_MAX + 1);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    // fp32 constants
    localparam logic [31:0] SCALE_MIN   = 32'h0DA2_4260;  // 1.0e-30
    localparam logic [25:0] RECIP_127   = 26'h204_0810;   // floor(2^32 / 127)
    localparam logic [9:0]  DEN_127_EXP = 10'd6;          // unbiased exponent of 127.0
    localparam logic [7:0]  EXP_SPECIAL = 8'hFF;
    localparam logic [7:0]  QMAX        = 8'd127;

    typedef struct packed {
        logic [31:0] sample_bits;
        logic        group_end;
    } t_in;

    typedef struct packed {
        logic              item_kind;
        logic [31:0]       scale_bits;
        logic signed [7:0] quant_value;
        logic              run_end;
    } t_out;

    localparam logic KIND_VALUE = 1'b0;
    localparam logic KIND_SCALE = 1'b1;

    // one closed group handed from front to back
    typedef struct packed {
        logic [30:0]      absmax;
        logic [CNT_W-1:0] count;
        logic             bank;
        logic             scale_only;
    } t_grp;

endpackage
`default_nettype wire

### rtl/gaq_ram.sv
`default_nettype none
module gaq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/gaq_fifo.sv
`default_nettype none
module gaq_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire gaq_pkg::t_grp i_data,
    input  wire logic          i_pop,
    output logic               o_valid,
    output logic               o_full,
    output gaq_pkg::t_grp      o_head
);

    gaq_pkg::t_grp r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_head  = r_mem[r_rp];

endmodule
`default_nettype wire

### rtl/gaq_front.sv
`default_nettype none
module gaq_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_wdata,
    input  wire logic                          i_in_valid,
    input  wire gaq_pkg::t_in                  i_in,
    input  wire logic                          i_q_full,
    output logic                               o_in_stall,
    output logic                               o_ram_we,
    output logic [gaq_pkg::ADDR_W-1:0]         o_ram_waddr,
    output logic [31:0]                        o_ram_wdata,
    output logic                               o_push,
    output gaq_pkg::t_grp                      o_grp
);

    logic                      r_scale_only;
    logic                      r_bank;
    logic [gaq_pkg::CNT_W-1:0] r_fill;
    logic [30:0]               r_max;

    logic                      acc;
    logic                      finite;
    logic [30:0]               n_max;
    logic [gaq_pkg::CNT_W-1:0] n_fill;
    logic                      close;

    // classify the incoming value
    always_comb begin
        acc    = i_in_valid && !o_in_stall;
        finite = (i_in.sample_bits[30:23] != gaq_pkg::EXP_SPECIAL);
        n_max  = (finite && (i_in.sample_bits[30:0] > r_max)) ? i_in.sample_bits[30:0] : r_max;
        n_fill = r_fill + 1'b1;
        close  = i_in.group_end || (n_fill == gaq_pkg::CNT_W'(gaq_pkg::GROUP_MAX));
    end

    // fill, running max and bank select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_only <= 1'b0;
            r_bank       <= 1'b0;
            r_fill       <= '0;
            r_max        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_scale_only <= i_cfg_wdata;
            end
            if (acc) begin
                if (close) begin
                    r_fill <= '0;
                    r_max  <= '0;
                    r_bank <= ~r_bank;
                end else begin
                    r_fill <= n_fill;
                    r_max  <= n_max;
                end
            end
        end
    end

    assign o_in_stall  = i_q_full;
    assign o_ram_we    = acc;
    assign o_ram_waddr = {r_bank, r_fill[gaq_pkg::IDX_W-1:0]};
    assign o_ram_wdata = i_in.sample_bits;
    assign o_push      = acc && close;
    assign o_grp       = '{absmax: n_max, count: n_fill, bank: r_bank, scale_only: r_scale_only};

endmodule
`default_nettype wire

### rtl/gaq_div.sv
`default_nettype none
module gaq_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [23:0] i_num,
    input  wire logic [23:0] i_den,
    output logic             o_done,
    output logic [23:0]      o_mant,
    output logic signed [1:0] o_off
);

    // 24 quotient bits plus a guard bit, one per cycle
    localparam logic [4:0] ITER = 5'd25;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [25:0] r_rem;
    logic [24:0] r_q;
    logic [23:0] r_den;
    logic        r_adj;

    logic [25:0] diff;
    logic        qbit;
    logic        up;
    logic [24:0] rounded;

    // restoring step
    always_comb begin
        diff = r_rem - {2'b00, r_den};
        qbit = !diff[25];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ITER - 1'b1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_adj <= (i_num < i_den);
            r_rem <= (i_num < i_den) ? {1'b0, i_num, 1'b0} : {2'b00, i_num};
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= {(qbit ? diff[24:0] : r_rem[24:0]), 1'b0};
            r_q   <= {r_q[23:0], qbit};
        end
    end

    // round to nearest even
    always_comb begin
        up      = r_q[0] && ((r_rem != '0) || r_q[1]);
        rounded = {1'b0, r_q[24:1]} + 25'(up);
        o_mant  = rounded[24] ? 24'h80_0000 : rounded[23:0];
        o_off   = $signed({1'b0, rounded[24]}) - $signed({1'b0, r_adj});
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

### rtl/gaq_back.sv
`default_nettype none
module gaq_back (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_q_valid,
    input  wire gaq_pkg::t_grp            i_grp,
    output logic                          o_pop,
    output logic [gaq_pkg::ADDR_W-1:0]    o_ram_raddr,
    input  wire logic [31:0]              i_ram_rdata,
    output logic                          o_out_valid,
    output gaq_pkg::t_out                 o_out,
    input  wire logic                     i_out_stall
);

    typedef enum logic [2:0] {
        S_IDLE, S_SREM, S_SRND, S_SOUT, S_RD, S_DAT, S_VDIV, S_VOUT
    } t_state;

    t_state                    r_state;
    logic [30:0]               r_scale;
    logic [49:0]               r_prod;
    logic [25:0]               r_quo;
    logic                      r_stk;
    logic [gaq_pkg::IDX_W-1:0] r_idx;
    logic                      r_sign;
    logic [7:0]                r_xexp;
    logic signed [7:0]         r_q;
    logic                      r_ov;
    gaq_pkg::t_out             r_out;

    logic                      div_start;
    logic [23:0]               div_num;
    logic [23:0]               div_den;
    logic                      div_done;
    logic [23:0]               div_mant;
    logic signed [1:0]         div_off;

    logic                      slot;
    logic                      last;
    logic [25:0]               s_q0;
    logic [32:0]               s_num;
    logic [32:0]               s_m127;
    logic [32:0]               s_rem;
    logic                      s_fix;
    logic                      s_hi;
    logic [23:0]               s_mant;
    logic                      s_grd;
    logic                      s_stk;
    logic [24:0]               s_rnd;
    logic signed [9:0]         e_s;
    logic [31:0]               scale_calc;
    logic signed [9:0]         e_q;
    logic [4:0]                sh;
    logic [23:0]               tq;
    logic [23:0]               mask;
    logic [23:0]               rem;
    logic [23:0]               half;
    logic                      up;
    logic [7:0]                mag;
    logic signed [7:0]         q_calc;

    gaq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_mant  (div_mant),
        .o_off   (div_off)
    );

    // output slot free
    assign slot = !r_ov || !i_out_stall;
    assign last = ({1'b0, r_idx} + 1'b1) == i_grp.count;

    // divider operands, value over scale
    always_comb begin
        div_start = (r_state == S_DAT)
                 && (i_ram_rdata[30:23] != 8'd0)
                 && (i_ram_rdata[30:23] != gaq_pkg::EXP_SPECIAL);
        div_num   = {1'b1, i_ram_rdata[22:0]};
        div_den   = {1'b1, r_scale[22:0]};
    end

    // absmax significand / 127 by reciprocal, corrected by the remainder
    always_comb begin
        s_q0   = r_prod[49:24];
        s_num  = {1'b0, 1'b1, i_grp.absmax[22:0], 8'd0};
        s_m127 = {s_q0, 7'd0} - {7'd0, s_q0};
        s_rem  = s_num - s_m127;
        s_fix  = (s_rem >= 33'd127);
    end

    // scale rounding, floored at 1e-30
    always_comb begin
        s_hi   = r_quo[25];
        s_mant = s_hi ? r_quo[25:2] : r_quo[24:1];
        s_grd  = s_hi ? r_quo[1] : r_quo[0];
        s_stk  = r_stk || (s_hi && r_quo[0]);
        s_rnd  = {1'b0, s_mant} + 25'(s_grd && (s_stk || s_mant[0]));
        e_s = $signed({2'b00, i_grp.absmax[30:23]}) - $signed(gaq_pkg::DEN_127_EXP)
            - 10'sd1 + $signed({9'd0, s_hi}) + $signed({9'd0, s_rnd[24]});
        scale_calc = {1'b0, e_s[7:0], s_rnd[22:0]};
        if (e_s < 10'sd1 || scale_calc < gaq_pkg::SCALE_MIN) begin
            scale_calc = gaq_pkg::SCALE_MIN;
        end
    end

    // quotient to integer, half to even, clamped
    always_comb begin
        e_q  = $signed({2'b00, r_xexp}) - $signed({2'b00, r_scale[30:23]}) + 10'(div_off);
        sh   = 5'(10'sd23 - e_q);
        tq   = div_mant >> sh;
        mask = (24'd1 << sh) - 24'd1;
        rem  = div_mant & mask;
        half = 24'd1 << (sh - 5'd1);
        up   = (rem > half) || ((rem == half) && tq[0]);
        mag  = tq[7:0] + 8'(up);
        if (e_q < -10'sd1) begin
            mag = 8'd0;
        end else if (e_q >= 10'sd7 || mag > gaq_pkg::QMAX) begin
            mag = gaq_pkg::QMAX;
        end
        q_calc = r_sign ? -$signed(mag) : $signed(mag);
    end

    assign o_ram_raddr = {i_grp.bank, r_idx};
    assign o_pop = ((r_state == S_SOUT) && slot && i_grp.scale_only)
                || ((r_state == S_VOUT) && slot && last);

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (i_q_valid) begin
                        if (i_grp.absmax[30:23] == 8'd0) begin
                            r_scale <= gaq_pkg::SCALE_MIN[30:0];
                            r_state <= S_SOUT;
                        end else begin
                            r_prod  <= 50'({1'b1, i_grp.absmax[22:0]})
                                     * 50'(gaq_pkg::RECIP_127);
                            r_state <= S_SREM;
                        end
                    end
                end
                S_SREM: begin
                    r_quo   <= s_q0 + 26'(s_fix);
                    r_stk   <= s_fix ? (s_rem != 33'd127) : (s_rem != 33'd0);
                    r_state <= S_SRND;
                end
                S_SRND: begin
                    r_scale <= scale_calc[30:0];
                    r_state <= S_SOUT;
                end
                S_SOUT: begin
                    if (slot) begin
                        r_ov  <= 1'b1;
                        r_out <= '{item_kind: gaq_pkg::KIND_SCALE,
                                   scale_bits: {1'b0, r_scale},
                                   quant_value: 8'sd0,
                                   run_end: i_grp.scale_only};
                        r_state <= i_grp.scale_only ? S_IDLE : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_DAT;
                end
                S_DAT: begin
                    r_sign <= i_ram_rdata[31];
                    r_xexp <= i_ram_rdata[30:23];
                    if (div_start) begin
                        r_state <= S_VDIV;
                    end else begin
                        r_q     <= 8'sd0;
                        r_state <= S_VOUT;
                    end
                end
                S_VDIV: begin
                    if (div_done) begin
                        r_q     <= q_calc;
                        r_state <= S_VOUT;
                    end
                end
                S_VOUT: begin
                    if (slot) begin
                        r_ov  <= 1'b1;
                        r_out <= '{item_kind: gaq_pkg::KIND_VALUE,
                                   scale_bits: 32'd0,
                                   quant_value: r_q,
                                   run_end: last};
                        if (last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    // checks
    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.item_kind == gaq_pkg::KIND_VALUE)
        |-> o_out.quant_value != -8'sd128)
        else $error("quantized value out of range");

    a_scale_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.item_kind == gaq_pkg::KIND_SCALE)
        |-> o_out.scale_bits >= gaq_pkg::SCALE_MIN)
        else $error("scale below floor");

    a_grp_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> i_q_valid)
        else $error("working on a group that is not queued");

    a_pop_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> o_out_valid && o_out.run_end)
        else $error("group released without its final transfer");

endmodule
`default_nettype wire

### rtl/group_absmax_int8_quantizer.sv
`default_nettype none
// Symmetric per-group int8 quantizer. fp32 values stream in, one per transfer,
// into one of two group buffers; a group closes on group_end or when 32 values
// are held. For each group the block sends the fp32 scale max(absmax/127, 1e-30)
// and then, unless scale-only mode is set, one int8 value per stored input in
// arrival order; run_end marks a group's final transfer. Input is accepted at one
// value per cycle while the back end works on the previous group. The scale comes
// from a reciprocal multiply, skipped when absmax is zero or denormal; each
// quantized value goes through a one-bit-per-cycle divider, which NaN, infinity,
// zero or denormal inputs bypass. With both buffers busy the input stalls until
// the back end finishes a group.
module group_absmax_int8_quantizer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_wdata,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire gaq_pkg::t_in   i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output gaq_pkg::t_out       o_out
);

    logic                       ram_we;
    logic [gaq_pkg::ADDR_W-1:0] ram_waddr;
    logic [31:0]                ram_wdata;
    logic [gaq_pkg::ADDR_W-1:0] ram_raddr;
    logic [31:0]                ram_rdata;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_valid;
    logic                       q_full;
    gaq_pkg::t_grp              q_in;
    gaq_pkg::t_grp              q_head;

    gaq_ram #(
        .WIDTH (32),
        .DEPTH (gaq_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    gaq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_push      (q_push),
        .o_grp       (q_in)
    );

    gaq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    gaq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_grp       (q_head),
        .o_pop       (q_pop),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule
`default_nettype wire

### verif/tb_group_absmax_int8_quantizer.sv
`timescale 1ns / 1ps
module tb_group_absmax_int8_quantizer;

    localparam int          IDLE_LIMIT = 6000;
    localparam int          HOLD_CYCLES = 900;
    localparam logic [31:0] F32_127 = 32'h42FE_0000;
    localparam logic [31:0] F32_INF = 32'h7F80_0000;

    // expected results of the quantizer, built per closed group
    class quant_scoreboard;
        logic [31:0]   group_vals[gaq_pkg::GROUP_MAX];
        logic [30:0]   peak_mag;
        int            fill;
        bit            scale_only;
        gaq_pkg::t_out expected_q[$];
        int            errors;
        int            matched;
        int            groups;

        function new();
            peak_mag = '0;
            fill = 0;
            scale_only = 0;
            errors = 0;
            matched = 0;
            groups = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        // fp32 division of two non-negative finite values, round to nearest even
        function logic [31:0] fdiv(logic [31:0] a, logic [31:0] b);
            longint unsigned ma, mb, quo, low, half, keep, res;
            int ea, eb, p, s, biased;
            bit sticky;
            if (a[30:0] == 0) return 32'h0;
            ma = a[22:0];
            mb = b[22:0];
            if (a[30:23] == 0) ea = -149;
            else begin
                ma = ma | (64'd1 << 23);
                ea = int'(a[30:23]) - 150;
            end
            if (b[30:23] == 0) eb = -149;
            else begin
                mb = mb | (64'd1 << 23);
                eb = int'(b[30:23]) - 150;
            end
            while (ma[23] == 0) begin
                ma = ma << 1;
                ea--;
            end
            while (mb[23] == 0) begin
                mb = mb << 1;
                eb--;
            end
            quo = (ma << 26) / mb;
            sticky = ((ma << 26) % mb) != 0;
            p = quo[26] ? 26 : 25;
            biased = p + ea - eb - 26 + 127;
            s = p - 23;
            if (biased < 1) s = s + (1 - biased);
            if (s > 60) s = 60;
            keep = quo >> s;
            low = quo & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            if (low > half || (low == half && (sticky || keep[0]))) keep = keep + 1;
            if (biased < 1) return keep[31:0];
            if (biased >= 255) return F32_INF;
            res = (longint'(biased - 1) << 23) + keep;
            if (res >= 64'h7F80_0000) return F32_INF;
            return res[31:0];
        endfunction

        // divide by scale, round half to even, clamp to +-127
        function logic signed [7:0] quantize(logic [31:0] v, logic [31:0] scale);
            logic [31:0] m;
            longint unsigned fx;
            int t;
            if (v[30:23] == 8'hFF) return 8'sd0;
            m = fdiv({1'b0, v[30:0]}, scale);
            if (m >= F32_127) t = 127;
            else if (m[30:23] < 126) t = 0;
            else begin
                fx = ({41'd1, m[22:0]}) << (int'(m[30:23]) - 126);
                t = int'(fx >> 24);
                if (fx[23:0] > 24'h80_0000 || (fx[23:0] == 24'h80_0000 && t[0])) t++;
                if (t > 127) t = 127;
            end
            return 8'(v[31] ? -t : t);
        endfunction

        // note one accepted input transfer
        function void note_input(gaq_pkg::t_in x);
            gaq_pkg::t_out r;
            logic [31:0] scale;
            group_vals[fill] = x.sample_bits;
            fill++;
            if (x.sample_bits[30:23] != 8'hFF && x.sample_bits[30:0] > peak_mag)
                peak_mag = x.sample_bits[30:0];
            if (!x.group_end && fill < gaq_pkg::GROUP_MAX) return;
            scale = fdiv({1'b0, peak_mag}, F32_127);
            if (scale < gaq_pkg::SCALE_MIN) scale = gaq_pkg::SCALE_MIN;
            r.item_kind = gaq_pkg::KIND_SCALE;
            r.scale_bits = scale;
            r.quant_value = '0;
            r.run_end = scale_only;
            expected_q.push_back(r);
            if (!scale_only) begin
                for (int i = 0; i < fill; i++) begin
                    r.item_kind = gaq_pkg::KIND_VALUE;
                    r.scale_bits = '0;
                    r.quant_value = quantize(group_vals[i], scale);
                    r.run_end = (i == fill - 1);
                    expected_q.push_back(r);
                end
            end
            groups++;
            peak_mag = '0;
            fill = 0;
        endfunction

        // compare one output transfer with the oldest expectation
        task check(gaq_pkg::t_out got);
            gaq_pkg::t_out e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            e = expected_q.pop_front();
            if (got.item_kind !== e.item_kind)
                report($sformatf("item_kind %b, want %b", got.item_kind, e.item_kind));
            if (got.scale_bits !== e.scale_bits)
                report($sformatf("scale_bits %h, want %h", got.scale_bits, e.scale_bits));
            if (got.quant_value !== e.quant_value)
                report($sformatf("quant_value %0d, want %0d", got.quant_value,
                                 e.quant_value));
            if (got.run_end !== e.run_end)
                report($sformatf("run_end %b, want %b", got.run_end, e.run_end));
            matched++;
        endtask
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic          i_cfg_wdata;
    logic          i_in_valid;
    logic          o_in_stall;
    gaq_pkg::t_in  i_in;
    logic          o_out_valid;
    logic          i_out_stall;
    gaq_pkg::t_out o_out;

    quant_scoreboard sb;
    bit   hold_go;
    bit   burst_mode;
    int   sent;
    int   idle_cycles;

    group_absmax_int8_quantizer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // clock
    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // output transfer check
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check(o_out);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // receiver stalls, with one long hold-off on request
    initial begin
        int n;
        int r;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_go) begin
                hold_go = 0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 9);
                if (r < 5) begin
                    i_out_stall <= 1'b0;
                    n = $urandom_range(1, 20);
                end else if (r < 8) begin
                    i_out_stall <= 1'b1;
                    n = $urandom_range(1, 3);
                end else if (r < 9) begin
                    i_out_stall <= 1'b1;
                    n = $urandom_range(10, 40);
                end else begin
                    i_out_stall <= 1'b0;
                    n = 1;
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // offer one input transfer and wait until it is taken
    task send_sample(logic [31:0] bits, logic last);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 40) gap = 0;
        else if (r < 85) gap = $urandom_range(1, 3);
        else if (r < 95) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= '{sample_bits: bits, group_end: last};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input('{sample_bits: bits, group_end: last});
        sent++;
    endtask

    // register write once the block has drained
    task write_mode(bit v);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.scale_only = v;
    endtask

    function logic [31:0] rand_sample();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v[30:23] = 8'($urandom_range(110, 140));
            5: v[30:23] = 8'($urandom_range(1, 254));
            6: begin
                v[30:23] = 8'($urandom_range(124, 133));
                v[15:0] = '0;
            end
            7: v[30:23] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'h01;
            8: v[30:23] = 8'hFF;
            default: ;
        endcase
        if ($urandom_range(0, 30) == 0) v[30:0] = '0;
        return v;
    endfunction

    // random groups, mostly short, some filling or overrunning the buffer
    task random_groups(int count);
        int len;
        int r;
        int stop_at;
        stop_at = sent + count;
        while (sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 80) len = $urandom_range(1, 8);
            else if (r < 95) len = $urandom_range(9, 32);
            else len = $urandom_range(33, 45);
            for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
        end
    endtask

    initial begin
        logic [31:0] ties[12];
        sb = new();
        hold_go = 0;
        burst_mode = 0;
        sent = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= 1'b0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_mode(1'b0);

        // scale of exactly one: ties, signed zeros, non-finite, denormal
        ties = '{32'h42FE_0000, 32'h4020_0000, 32'h4060_0000, 32'hBF00_0000,
                 32'h3FC0_0000, 32'hC020_0000, 32'h0000_0000, 32'h8000_0000,
                 32'h7F80_0000, 32'h7FC0_0000, 32'h0000_0001, 32'h42FD_0000};
        foreach (ties[i]) send_sample(ties[i], i == 11);
        // largest finite value alone, a group of infinity, NaN and negative zero, all ones, -127 with 0.5
        send_sample(32'h7F7F_FFFF, 1'b1);
        send_sample(32'hFF80_0000, 1'b0);
        send_sample(32'hFFC0_0001, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b1);
        send_sample(32'hC2FE_0000, 1'b0);
        send_sample(32'h3F00_0000, 1'b1);

        write_mode(1'b1);
        send_sample(32'h7F7F_FFFF, 1'b1);
        random_groups(40);

        write_mode(1'b0);
        random_groups(140);

        // long receiver hold-off while the sender keeps offering
        burst_mode = 1;
        hold_go = 1;
        random_groups(70);
        burst_mode = 0;

        write_mode(1'b1);
        random_groups(30);
        write_mode(1'b0);
        random_groups(40);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.pending() > 0) sb.report($sformatf("%0d results never came", sb.pending()));
        $display("run: %0d input values in %0d groups, %0d results checked",
                 sent, sb.groups, sb.matched);
        $display("covered both modes, ties, non-finite and denormal inputs, full buffers");
        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
